>>> rtl/core/rc4_pkg.sv
// rc4_pkg: shared types and constants of the rc4 stream cipher
// used by the controller, the datapath and the top level; depends on nothing
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int TABLE_DEPTH   = 256;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_WORD_W    = 64;
    localparam int KEY_BYTES_ALL = 32;
    localparam int KEY_IDX_W     = 5;
    localparam int KEY_LEN_W     = 6;
    localparam int CFG_IDX_W     = 3;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_KEY_WORD_0 = 3'd0;
    localparam cfg_idx_t REG_KEY_WORD_1 = 3'd1;
    localparam cfg_idx_t REG_KEY_WORD_2 = 3'd2;
    localparam cfg_idx_t REG_KEY_WORD_3 = 3'd3;
    localparam cfg_idx_t REG_KEY_LENGTH = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_K_RD_N,
        ST_K_RD_J,
        ST_K_WR_N,
        ST_K_WR_J,
        ST_G_RD_I,
        ST_G_RD_J,
        ST_G_SWAP,
        ST_G_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_K_RD_N,
        OP_K_RD_J,
        OP_K_WR_N,
        OP_K_WR_J,
        OP_G_RD_I,
        OP_G_RD_J,
        OP_G_SWAP,
        OP_G_WR_J,
        OP_G_FINISH
    } dp_op_t;

    typedef struct packed {
        logic need_sched;
        logic cnt_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/rc4_in_if.sv
// rc4_in_if: input channel of the rc4 cipher, valid/ready with data byte and last flag
// depends on nothing
`default_nettype none

interface rc4_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_message;

    modport source (output valid, output data_byte, output last_of_message, input ready);
    modport sink   (input valid, input data_byte, input last_of_message, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rc4_out_if.sv
// rc4_out_if: output channel of the rc4 cipher, valid/ready with the result byte
// depends on nothing
`default_nettype none

interface rc4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rc4_dp.sv
// rc4_dp: rc4 datapath with key registers, permutation memory, indices and output register
// depends on rc4_pkg; driven by rc4_ctrl through a datapath op code
`default_nettype none

module rc4_dp #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire rc4_pkg::cfg_idx_t                cfg_index,
    input  wire logic [rc4_pkg::KEY_WORD_W-1:0]   cfg_data,
    input  wire logic [rc4_pkg::BYTE_W-1:0]       in_data,
    input  wire logic                             in_last,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic [rc4_pkg::BYTE_W-1:0]            out_byte,
    input  wire rc4_pkg::dp_op_t                  op,
    output rc4_pkg::dp_status_t                   status
);

    localparam int BW     = rc4_pkg::BYTE_W;
    localparam int LW     = rc4_pkg::KEY_LEN_W;
    localparam int IW     = rc4_pkg::KEY_IDX_W;
    localparam int KPOS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_KEY_BYTES);

    // configuration
    logic [rc4_pkg::KEY_WORD_W-1:0] key_word_reg [rc4_pkg::KEY_WORDS];
    logic [LW-1:0]                  key_len_reg;

    // control state
    logic [BW-1:0]     i_reg, i_next;
    logic [BW-1:0]     j_reg, j_next;
    logic [BW-1:0]     cnt_reg, cnt_next;
    logic [KPOS_W-1:0] kpos_reg, kpos_next;
    logic              need_sched_reg, need_sched_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [BW-1:0] data_reg;
    logic          last_reg;
    logic [BW-1:0] hold_reg;
    logic [BW-1:0] t_reg;
    logic [BW-1:0] out_byte_reg;
    logic [BW-1:0] rdata_a_reg;
    logic [BW-1:0] rdata_b_reg;

    logic [BW-1:0] perm_mem [rc4_pkg::TABLE_DEPTH];

    logic [BW-1:0] key_bytes [rc4_pkg::KEY_BYTES_ALL];
    logic [BW-1:0] key_byte;
    logic [LW-1:0] len_eff;
    logic [LW-1:0] kpos_inc;
    logic [BW-1:0] j_ksa;
    logic [BW-1:0] j_gen;
    logic [BW-1:0] i_inc;
    logic [BW-1:0] t_sum;
    logic [BW-1:0] ks;
    logic          out_free;

    logic          mem_we;
    logic [BW-1:0] mem_waddr;
    logic [BW-1:0] mem_wdata;
    logic          re_a;
    logic [BW-1:0] addr_a;
    logic          re_b;
    logic [BW-1:0] addr_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < rc4_pkg::KEY_WORDS; w++)
            begin
                key_word_reg[w] <= '0;
            end
            key_len_reg <= rc4_pkg::KEY_LEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rc4_pkg::REG_KEY_WORD_0: key_word_reg[0] <= cfg_data;
                rc4_pkg::REG_KEY_WORD_1: key_word_reg[1] <= cfg_data;
                rc4_pkg::REG_KEY_WORD_2: key_word_reg[2] <= cfg_data;
                rc4_pkg::REG_KEY_WORD_3: key_word_reg[3] <= cfg_data;
                rc4_pkg::REG_KEY_LENGTH: key_len_reg     <= cfg_data[LW-1:0];
                default:                 key_len_reg     <= key_len_reg;
            endcase
        end
    end

    always_comb
    begin
        for (int w = 0; w < rc4_pkg::KEY_WORDS; w++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                key_bytes[w*8 + b] = key_word_reg[w][b*BW +: BW];
            end
        end
    end

    assign key_byte = key_bytes[IW'(kpos_reg)];
    assign len_eff  = (key_len_reg == '0)     ? LW'(1) :
                      (key_len_reg > MAX_LEN) ? MAX_LEN : key_len_reg;
    assign kpos_inc = LW'(kpos_reg) + LW'(1);

    assign j_ksa = BW'(j_reg + rdata_a_reg + key_byte);
    assign j_gen = BW'(j_reg + rdata_a_reg);
    assign i_inc = BW'(i_reg + BW'(1));
    assign t_sum = BW'(rdata_a_reg + rdata_b_reg);

    // values after the swap: S[j] holds old S[i], S[i] holds old S[j]
    assign ks = (t_reg == j_reg) ? hold_reg :
                (t_reg == i_reg) ? rdata_b_reg : rdata_a_reg;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = rdata_b_reg;
        re_a      = 1'b0;
        addr_a    = cnt_reg;
        re_b      = 1'b0;
        addr_b    = j_ksa;
        case (op)
            rc4_pkg::OP_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = cnt_reg;
            end
            rc4_pkg::OP_K_RD_N:
            begin
                re_a = 1'b1;
            end
            rc4_pkg::OP_K_RD_J:
            begin
                re_b = 1'b1;
            end
            rc4_pkg::OP_K_WR_N:
            begin
                mem_we = 1'b1;
            end
            rc4_pkg::OP_K_WR_J:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = rdata_a_reg;
            end
            rc4_pkg::OP_G_RD_I:
            begin
                re_a   = 1'b1;
                addr_a = i_inc;
            end
            rc4_pkg::OP_G_RD_J:
            begin
                re_b   = 1'b1;
                addr_b = j_gen;
            end
            rc4_pkg::OP_G_SWAP:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                re_a      = 1'b1;
                addr_a    = t_sum;
            end
            rc4_pkg::OP_G_WR_J, rc4_pkg::OP_G_FINISH:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = hold_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
        if (re_a)
        begin
            rdata_a_reg <= perm_mem[addr_a];
        end
        if (re_b)
        begin
            rdata_b_reg <= perm_mem[addr_b];
        end
    end

    always_comb
    begin
        i_next          = i_reg;
        j_next          = j_reg;
        cnt_next        = cnt_reg;
        kpos_next       = kpos_reg;
        need_sched_next = need_sched_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (op)
            rc4_pkg::OP_LOAD:
            begin
                cnt_next = '0;
            end
            rc4_pkg::OP_INIT:
            begin
                cnt_next  = BW'(cnt_reg + BW'(1));
                i_next    = '0;
                j_next    = '0;
                kpos_next = '0;
            end
            rc4_pkg::OP_K_RD_J:
            begin
                j_next = j_ksa;
            end
            rc4_pkg::OP_K_WR_J:
            begin
                cnt_next  = BW'(cnt_reg + BW'(1));
                kpos_next = (kpos_inc >= len_eff) ? '0 : KPOS_W'(kpos_inc);
                if (cnt_reg == '1)
                begin
                    i_next = '0;
                    j_next = '0;
                end
            end
            rc4_pkg::OP_G_RD_I:
            begin
                i_next = i_inc;
            end
            rc4_pkg::OP_G_RD_J:
            begin
                j_next = j_gen;
            end
            rc4_pkg::OP_G_FINISH:
            begin
                out_valid_next  = 1'b1;
                need_sched_next = last_reg;
            end
            default:
            begin
                i_next = i_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg          <= '0;
            j_reg          <= '0;
            cnt_reg        <= '0;
            kpos_reg       <= '0;
            need_sched_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            i_reg          <= i_next;
            j_reg          <= j_next;
            cnt_reg        <= cnt_next;
            kpos_reg       <= kpos_next;
            need_sched_reg <= need_sched_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == rc4_pkg::OP_LOAD)
        begin
            data_reg <= in_data;
            last_reg <= in_last;
        end
        if (op == rc4_pkg::OP_G_SWAP)
        begin
            hold_reg <= rdata_a_reg;
            t_reg    <= t_sum;
        end
        if (op == rc4_pkg::OP_G_FINISH)
        begin
            out_byte_reg <= data_reg ^ ks;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;
    assign status.need_sched = need_sched_reg;
    assign status.cnt_last   = (cnt_reg == '1);
    assign status.out_free   = out_free;

    a_i_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (op == rc4_pkg::OP_G_RD_I) |=> (i_reg == BW'($past(i_reg) + BW'(1))))
        else $error("generator index i did not advance by one");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (op == rc4_pkg::OP_G_FINISH) |=> out_valid_reg)
        else $error("finished byte not presented on the output");

    a_sched_ij_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (op == rc4_pkg::OP_K_WR_J && cnt_reg == '1) |=> (i_reg == '0 && j_reg == '0))
        else $error("indices not cleared at end of key schedule");

endmodule

`default_nettype wire

>>> rtl/core/rc4_ctrl.sv
// rc4_ctrl: controller state machine of the rc4 cipher, sequences schedule and generator steps
// depends on rc4_pkg; drives rc4_dp through a datapath op code and reads its status
`default_nettype none

module rc4_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rc4_pkg::dp_status_t status,
    output rc4_pkg::dp_op_t          op
);

    rc4_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.need_sched ? rc4_pkg::ST_INIT : rc4_pkg::ST_G_RD_I;
                end
            end
            rc4_pkg::ST_INIT:
            begin
                if (status.cnt_last)
                begin
                    state_next = rc4_pkg::ST_K_RD_N;
                end
            end
            rc4_pkg::ST_K_RD_N: state_next = rc4_pkg::ST_K_RD_J;
            rc4_pkg::ST_K_RD_J: state_next = rc4_pkg::ST_K_WR_N;
            rc4_pkg::ST_K_WR_N: state_next = rc4_pkg::ST_K_WR_J;
            rc4_pkg::ST_K_WR_J:
            begin
                state_next = status.cnt_last ? rc4_pkg::ST_G_RD_I : rc4_pkg::ST_K_RD_N;
            end
            rc4_pkg::ST_G_RD_I: state_next = rc4_pkg::ST_G_RD_J;
            rc4_pkg::ST_G_RD_J: state_next = rc4_pkg::ST_G_SWAP;
            rc4_pkg::ST_G_SWAP: state_next = rc4_pkg::ST_G_DONE;
            rc4_pkg::ST_G_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
            default: state_next = rc4_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        op       = rc4_pkg::OP_NONE;
        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                op       = in_valid ? rc4_pkg::OP_LOAD : rc4_pkg::OP_NONE;
            end
            rc4_pkg::ST_INIT:   op = rc4_pkg::OP_INIT;
            rc4_pkg::ST_K_RD_N: op = rc4_pkg::OP_K_RD_N;
            rc4_pkg::ST_K_RD_J: op = rc4_pkg::OP_K_RD_J;
            rc4_pkg::ST_K_WR_N: op = rc4_pkg::OP_K_WR_N;
            rc4_pkg::ST_K_WR_J: op = rc4_pkg::OP_K_WR_J;
            rc4_pkg::ST_G_RD_I: op = rc4_pkg::OP_G_RD_I;
            rc4_pkg::ST_G_RD_J: op = rc4_pkg::OP_G_RD_J;
            rc4_pkg::ST_G_SWAP: op = rc4_pkg::OP_G_SWAP;
            rc4_pkg::ST_G_DONE:
            begin
                op = status.out_free ? rc4_pkg::OP_G_FINISH : rc4_pkg::OP_G_WR_J;
            end
            default: op = rc4_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rc4_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_sched_to_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_K_WR_J && status.cnt_last) |=> (state_reg == rc4_pkg::ST_G_RD_I))
        else $error("key schedule did not hand over to the generator");

    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_G_DONE && !status.out_free) |=> (state_reg == rc4_pkg::ST_G_DONE))
        else $error("left final step while output register still full");

    a_new_msg_sched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_IDLE && in_valid && status.need_sched)
            |=> (state_reg == rc4_pkg::ST_INIT))
        else $error("new message skipped the key schedule");

endmodule

`default_nettype wire

>>> rtl/core/rc4_stream_cipher.sv
// rc4_stream_cipher: top level of the rc4 stream cipher
// depends on rc4_pkg, rc4_in_if, rc4_out_if, rc4_ctrl and rc4_dp
`default_nettype none

// RC4 stream cipher, one byte per transfer; encrypt and decrypt are the same operation.
// The first byte after reset, or after a byte marked last_of_message, runs the key
// schedule first with the key and length as configured at that moment: load the
// identity permutation, then 256 swap steps (read S[n], read S[j], write S[n], write S[j]).
// Each byte then goes through accept, read S[i], read S[j], swap with keystream read and
// output; the 256 x 8 permutation memory has a single write port. A finished byte waits
// in the output register while the next byte is already taken in. The user must write
// configuration only while no byte is in flight; the block does not enforce it.
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    rc4_in_if.sink                              in_stream,
    rc4_out_if.source                           out_stream,
    input  wire logic                           cfg_write,
    input  wire rc4_pkg::cfg_idx_t              cfg_index,
    input  wire logic [rc4_pkg::KEY_WORD_W-1:0] cfg_data
);

    rc4_pkg::dp_op_t     op;
    rc4_pkg::dp_status_t status;
    logic                in_ready;
    logic                out_valid;
    logic [7:0]          out_byte;

    rc4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_stream.valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    rc4_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_stream.data_byte),
        .in_last   (in_stream.last_of_message),
        .out_ready (out_stream.ready),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .op        (op),
        .status    (status)
    );

    assign in_stream.ready     = in_ready;
    assign out_stream.valid    = out_valid;
    assign out_stream.out_byte = out_byte;

endmodule

`default_nettype wire
